FILE: rtl/core/dibbmp_pkg.sv
// Shared types, constants and the microcode ROM of the DIB to BMP header wrapper.
package dibbmp_pkg;

    // Payload of one input transfer and of one result transfer.
    typedef struct packed {
        logic [7:0]  in_byte;
        logic [31:0] image_length;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [31:0] output_length;
        logic        status;
        logic        run_end;
        logic        image_end;
    } t_out;

    // Conversion variant of the current image.
    typedef logic [1:0] t_var;
    localparam t_var VAR_NONE    = 2'd0;
    localparam t_var VAR_PASS    = 2'd1;
    localparam t_var VAR_PLAIN   = 2'd2;
    localparam t_var VAR_REWRITE = 2'd3;

    // Header store: bytes 0..35 are replayed, so only those are kept.
    localparam int HDR_DEPTH = 36;
    localparam int HDR_AW    = $clog2(HDR_DEPTH);
    typedef logic [HDR_AW-1:0] t_haddr;

    localparam logic [31:0] DECIDE_POS  = 32'd35;
    localparam logic [31:0] MASK_POS    = 32'd39;
    localparam logic [31:0] MIN_LEN     = 32'd40;
    localparam logic [31:0] INFO_HDR40  = 32'd40;
    localparam logic [31:0] COMP_RGB    = 32'd0;
    localparam logic [31:0] COMP_FIELDS = 32'd3;
    localparam logic [15:0] BPP_32      = 16'd32;
    localparam logic [15:0] BPP_8       = 16'd8;
    localparam logic [31:0] FILE_HDR_LEN  = 32'd14;
    localparam logic [31:0] FIELDS_LEN    = 32'd12;
    localparam logic [31:0] REWRITE_GROW  = 32'd30;
    localparam logic [7:0]  CHAR_B      = 8'h42;
    localparam logic [7:0]  CHAR_M      = 8'h4D;
    localparam logic [7:0]  MASK_BYTE   = 8'hFF;
    localparam logic [7:0]  REWRITE_OFFS = 8'd70;
    localparam logic [7:0]  INFO_HDR56  = 8'd56;

    // Microcode opcodes and emit sources.
    typedef logic [1:0] t_op;
    localparam t_op OP_WAIT     = 2'd0;
    localparam t_op OP_EMIT     = 2'd1;
    localparam t_op OP_ACC_BASE = 2'd2;
    localparam t_op OP_ACC_PAL  = 2'd3;

    typedef logic [2:0] t_src;
    localparam t_src SRC_CONST = 3'd0;  // konst on every repetition
    localparam t_src SRC_LE32  = 3'd1;  // konst, then zero bytes
    localparam t_src SRC_TOTAL = 3'd2;  // byte of the file size
    localparam t_src SRC_ACC   = 3'd3;  // byte of the computed pixel offset
    localparam t_src SRC_STORE = 3'd4;  // replay from the header store
    localparam t_src SRC_MASK  = 3'd5;  // RGBA channel masks

    typedef logic [4:0] t_pc;
    typedef logic [5:0] t_cnt;

    localparam t_pc PC_IDLE      = 5'd0;
    localparam t_pc PC_PASS_ADDR = 5'd1;
    localparam t_pc PC_PASS_COPY = 5'd2;
    localparam t_pc PC_RW_B      = 5'd3;
    localparam t_pc PC_RW_M      = 5'd4;
    localparam t_pc PC_RW_SIZE   = 5'd5;
    localparam t_pc PC_RW_RSVD   = 5'd6;
    localparam t_pc PC_RW_OFFS   = 5'd7;
    localparam t_pc PC_RW_HDRSZ  = 5'd8;
    localparam t_pc PC_RW_COPY_A = 5'd9;
    localparam t_pc PC_RW_COMP   = 5'd10;
    localparam t_pc PC_RW_COPY_B = 5'd11;
    localparam t_pc PC_PL_BASE   = 5'd12;
    localparam t_pc PC_PL_PAL    = 5'd13;
    localparam t_pc PC_PL_B      = 5'd14;
    localparam t_pc PC_PL_M      = 5'd15;
    localparam t_pc PC_PL_SIZE   = 5'd16;
    localparam t_pc PC_PL_RSVD   = 5'd17;
    localparam t_pc PC_PL_OFFS   = 5'd18;
    localparam t_pc PC_PL_COPY   = 5'd19;
    localparam t_pc PC_MASK      = 5'd20;

    // One control word: a step runs cnt+1 times, then jumps to nxt.
    typedef struct packed {
        t_op    op;
        t_src   src;
        logic [7:0] konst;
        t_cnt   cnt;
        logic   ld_addr;   // load the store read address when the step ends
        t_haddr addr;
        logic   fin;       // last result of the run
        t_pc    nxt;
    } t_uword;

    function automatic t_uword f_uw(t_op op, t_src src, logic [7:0] konst, t_cnt cnt,
                                    logic ld_addr, t_haddr addr, logic fin, t_pc nxt);
        t_uword w;
        w.op      = op;
        w.src     = src;
        w.konst   = konst;
        w.cnt     = cnt;
        w.ld_addr = ld_addr;
        w.addr    = addr;
        w.fin     = fin;
        w.nxt     = nxt;
        return w;
    endfunction

    function automatic t_uword f_ucode(t_pc pc);
        t_uword w;
        case (pc)
            // pass: copy bytes 0..35 unchanged
            PC_PASS_ADDR: w = f_uw(OP_ACC_BASE, SRC_CONST, 8'd0, 6'd0, 1'b1, 6'd0, 1'b0,
                                   PC_PASS_COPY);
            PC_PASS_COPY: w = f_uw(OP_EMIT, SRC_STORE, 8'd0, 6'd35, 1'b0, 6'd0, 1'b1,
                                   PC_IDLE);
            // rewrite: file header, then a 56-byte bitfields header
            PC_RW_B:      w = f_uw(OP_EMIT, SRC_CONST, CHAR_B, 6'd0, 1'b0, 6'd0, 1'b0, PC_RW_M);
            PC_RW_M:      w = f_uw(OP_EMIT, SRC_CONST, CHAR_M, 6'd0, 1'b0, 6'd0, 1'b0,
                                   PC_RW_SIZE);
            PC_RW_SIZE:   w = f_uw(OP_EMIT, SRC_TOTAL, 8'd0, 6'd3, 1'b0, 6'd0, 1'b0,
                                   PC_RW_RSVD);
            PC_RW_RSVD:   w = f_uw(OP_EMIT, SRC_LE32, 8'd0, 6'd3, 1'b0, 6'd0, 1'b0,
                                   PC_RW_OFFS);
            PC_RW_OFFS:   w = f_uw(OP_EMIT, SRC_LE32, REWRITE_OFFS, 6'd3, 1'b0, 6'd0, 1'b0,
                                   PC_RW_HDRSZ);
            PC_RW_HDRSZ:  w = f_uw(OP_EMIT, SRC_LE32, INFO_HDR56, 6'd3, 1'b1, 6'd4, 1'b0,
                                   PC_RW_COPY_A);
            PC_RW_COPY_A: w = f_uw(OP_EMIT, SRC_STORE, 8'd0, 6'd11, 1'b0, 6'd0, 1'b0,
                                   PC_RW_COMP);
            PC_RW_COMP:   w = f_uw(OP_EMIT, SRC_LE32, COMP_FIELDS[7:0], 6'd3, 1'b1, 6'd20,
                                   1'b0, PC_RW_COPY_B);
            PC_RW_COPY_B: w = f_uw(OP_EMIT, SRC_STORE, 8'd0, 6'd15, 1'b0, 6'd0, 1'b1,
                                   PC_IDLE);
            // plain: compute the pixel offset, file header, then bytes 0..35
            PC_PL_BASE:   w = f_uw(OP_ACC_BASE, SRC_CONST, 8'd0, 6'd0, 1'b0, 6'd0, 1'b0,
                                   PC_PL_PAL);
            PC_PL_PAL:    w = f_uw(OP_ACC_PAL, SRC_CONST, 8'd0, 6'd0, 1'b0, 6'd0, 1'b0,
                                   PC_PL_B);
            PC_PL_B:      w = f_uw(OP_EMIT, SRC_CONST, CHAR_B, 6'd0, 1'b0, 6'd0, 1'b0, PC_PL_M);
            PC_PL_M:      w = f_uw(OP_EMIT, SRC_CONST, CHAR_M, 6'd0, 1'b0, 6'd0, 1'b0,
                                   PC_PL_SIZE);
            PC_PL_SIZE:   w = f_uw(OP_EMIT, SRC_TOTAL, 8'd0, 6'd3, 1'b0, 6'd0, 1'b0,
                                   PC_PL_RSVD);
            PC_PL_RSVD:   w = f_uw(OP_EMIT, SRC_LE32, 8'd0, 6'd3, 1'b0, 6'd0, 1'b0,
                                   PC_PL_OFFS);
            PC_PL_OFFS:   w = f_uw(OP_EMIT, SRC_ACC, 8'd0, 6'd3, 1'b1, 6'd0, 1'b0,
                                   PC_PL_COPY);
            PC_PL_COPY:   w = f_uw(OP_EMIT, SRC_STORE, 8'd0, 6'd35, 1'b0, 6'd0, 1'b1,
                                   PC_IDLE);
            // rewrite, after source byte 39: four channel masks
            PC_MASK:      w = f_uw(OP_EMIT, SRC_MASK, 8'd0, 6'd15, 1'b0, 6'd0, 1'b1, PC_IDLE);
            default:      w = f_uw(OP_WAIT, SRC_CONST, 8'd0, 6'd0, 1'b0, 6'd0, 1'b0, PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/dib_to_bmp_header_wrapper_unit.sv
// DIB to BMP file wrapper: microcoded header sequencer, header store and output register.
//
// Takes a bitmap one byte per transfer, each carrying the bitmap's total
// length, and produces the bytes of a complete BMP file. Bytes 0..34 give no
// result; they are held in a 36-entry header store while the header size, bit
// count, compression and palette count are captured. Byte 35 picks the
// variant: input starting with "BM" passes unchanged, a 32-bit uncompressed
// image with a 40-byte header is rewritten to a 56-byte bitfields header
// (pixel offset 70), and anything else gets a 14-byte file header in front.
// Byte 35 then starts a burst from the microcode program: 36 results for
// pass, 50 for rewrite and 50 for plain (which first computes the pixel
// offset). During a burst no input is taken. Every later byte is passed
// straight to the output register, one transfer per cycle while the output
// is not stalled; in the rewrite variant byte 39 adds 16 mask bytes. A bitmap
// that ends before its variant is decided gives one error result (status 1,
// length 0). The output register parts the two sides, so a new byte is taken
// while the previous result is being transferred.
module dib_to_bmp_header_wrapper_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dibbmp_pkg::t_in    i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dibbmp_pkg::t_out   o_out_data
);

    // Image position and variant.
    logic [31:0]          r_pos,   n_pos;
    dibbmp_pkg::t_var     r_var,   n_var;
    logic                 r_last,  n_last;
    logic [31:0]          r_total, n_total;

    // Header fields captured as the bytes go by.
    logic [31:0]          r_hsize;
    logic [15:0]          r_bits;
    logic [31:0]          r_comp;
    logic [31:0]          r_used;

    // Sequencer.
    dibbmp_pkg::t_pc      r_pc,    n_pc;
    dibbmp_pkg::t_cnt     r_rep,   n_rep;
    dibbmp_pkg::t_uword   w;
    logic [31:0]          r_acc,   n_acc;

    // Header store.
    logic [7:0]           mem [dibbmp_pkg::HDR_DEPTH];
    dibbmp_pkg::t_haddr   r_raddr, n_raddr;
    logic [7:0]           r_rdata;
    logic                 wr_en;

    // Output register.
    logic                 r_out_valid, n_out_valid;
    dibbmp_pkg::t_out     r_out,       n_out;

    logic                 slot_free;
    logic                 accept;
    logic                 in_store;
    logic                 last;
    logic                 decide;
    dibbmp_pkg::t_var     dec_var;
    dibbmp_pkg::t_var     eff_var;
    logic                 step_go;
    logic                 step_done;
    logic [7:0]           seq_byte;
    logic [31:0]          pal_base;
    logic [31:0]          palette;
    logic                 mask_run;

    assign w          = dibbmp_pkg::f_ucode(r_pc);
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_pc == dibbmp_pkg::PC_IDLE) && slot_free;
    assign accept     = i_in_valid && o_in_ready;
    assign in_store   = r_pos < 32'(dibbmp_pkg::HDR_DEPTH);
    assign wr_en      = accept && in_store;

    // Last byte of an image: wide compare so no length wraps.
    assign last = ({1'b0, r_pos} + 33'd1) >= {1'b0, i_in_data.image_length};

    assign decide = (r_var == dibbmp_pkg::VAR_NONE) && (r_pos == dibbmp_pkg::DECIDE_POS)
                  && (i_in_data.image_length >= dibbmp_pkg::MIN_LEN);

    always_comb begin
        if (r_hsize[7:0] == dibbmp_pkg::CHAR_B && r_hsize[15:8] == dibbmp_pkg::CHAR_M) begin
            dec_var = dibbmp_pkg::VAR_PASS;
        end else if (r_bits == dibbmp_pkg::BPP_32 && r_hsize == dibbmp_pkg::INFO_HDR40
                     && r_comp == dibbmp_pkg::COMP_RGB) begin
            dec_var = dibbmp_pkg::VAR_REWRITE;
        end else begin
            dec_var = dibbmp_pkg::VAR_PLAIN;
        end
    end

    assign eff_var = decide ? dec_var : r_var;

    // File size for this byte's length under the variant in force.
    always_comb begin
        case (eff_var)
            dibbmp_pkg::VAR_PASS:    n_total = i_in_data.image_length;
            dibbmp_pkg::VAR_REWRITE: n_total = i_in_data.image_length
                                               + dibbmp_pkg::REWRITE_GROW;
            default:                 n_total = i_in_data.image_length
                                               + dibbmp_pkg::FILE_HDR_LEN;
        endcase
    end

    // Palette bytes: only for 1..8 bits per pixel.
    assign pal_base = (r_used != 32'd0) ? r_used : (32'd1 << r_bits[3:0]);
    assign palette  = (r_bits != 16'd0 && r_bits <= dibbmp_pkg::BPP_8)
                    ? {pal_base[29:0], 2'b00} : 32'd0;

    // Step control: an emit step waits for a free output slot.
    assign step_go   = (w.op == dibbmp_pkg::OP_EMIT) ? slot_free
                                                      : (w.op != dibbmp_pkg::OP_WAIT);
    assign step_done = step_go && (r_rep == w.cnt);

    always_comb begin
        case (w.src)
            dibbmp_pkg::SRC_CONST: seq_byte = w.konst;
            dibbmp_pkg::SRC_LE32:  seq_byte = (r_rep[1:0] == 2'd0) ? w.konst : 8'd0;
            dibbmp_pkg::SRC_TOTAL: seq_byte = r_total[{r_rep[1:0], 3'b000} +: 8];
            dibbmp_pkg::SRC_ACC:   seq_byte = r_acc[{r_rep[1:0], 3'b000} +: 8];
            dibbmp_pkg::SRC_STORE: seq_byte = r_rdata;
            dibbmp_pkg::SRC_MASK:  seq_byte = (r_rep[1:0] == r_rep[3:2])
                                              ? dibbmp_pkg::MASK_BYTE : 8'd0;
            default:               seq_byte = 8'd0;
        endcase
    end

    assign mask_run = (r_var == dibbmp_pkg::VAR_REWRITE) && (r_pos == dibbmp_pkg::MASK_POS);

    always_comb begin
        n_pos       = r_pos;
        n_var       = r_var;
        n_last      = r_last;
        n_pc        = r_pc;
        n_rep       = r_rep;
        n_acc       = r_acc;
        n_raddr     = r_raddr;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // Drop the held result once it is transferred.
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (accept) begin
            n_pos = last ? 32'd0 : r_pos + 32'd1;
            n_var = last ? dibbmp_pkg::VAR_NONE : eff_var;
            if (r_var != dibbmp_pkg::VAR_NONE) begin
                // Pass the byte straight through.
                n_out_valid           = 1'b1;
                n_out.out_byte        = i_in_data.in_byte;
                n_out.output_length   = n_total;
                n_out.status          = 1'b0;
                n_out.run_end         = !mask_run;
                n_out.image_end       = !mask_run && last;
                if (mask_run) begin
                    n_pc   = dibbmp_pkg::PC_MASK;
                    n_last = last;
                end
            end else if (last) begin
                // Image ended before the variant was known.
                n_out_valid           = 1'b1;
                n_out.out_byte        = 8'd0;
                n_out.output_length   = 32'd0;
                n_out.status          = 1'b1;
                n_out.run_end         = 1'b1;
                n_out.image_end       = 1'b1;
            end else if (decide) begin
                n_last = 1'b0;
                case (dec_var)
                    dibbmp_pkg::VAR_PASS:    n_pc = dibbmp_pkg::PC_PASS_ADDR;
                    dibbmp_pkg::VAR_REWRITE: n_pc = dibbmp_pkg::PC_RW_B;
                    default:                 n_pc = dibbmp_pkg::PC_PL_BASE;
                endcase
            end
        end

        if (step_go) begin
            if (step_done) begin
                n_pc  = w.nxt;
                n_rep = '0;
                if (w.ld_addr) begin
                    n_raddr = w.addr;
                end
            end else begin
                n_rep = r_rep + 6'd1;
                if (w.src == dibbmp_pkg::SRC_STORE) begin
                    n_raddr = r_raddr + dibbmp_pkg::t_haddr'(1);
                end
            end
            case (w.op)
                dibbmp_pkg::OP_EMIT: begin
                    n_out_valid         = 1'b1;
                    n_out.out_byte      = seq_byte;
                    n_out.output_length = r_total;
                    n_out.status        = 1'b0;
                    n_out.run_end       = step_done && w.fin;
                    n_out.image_end     = step_done && w.fin && r_last;
                end
                dibbmp_pkg::OP_ACC_BASE: begin
                    n_acc = r_hsize + dibbmp_pkg::FILE_HDR_LEN
                          + ((r_comp == dibbmp_pkg::COMP_FIELDS
                              && r_hsize == dibbmp_pkg::INFO_HDR40)
                             ? dibbmp_pkg::FIELDS_LEN : 32'd0);
                end
                dibbmp_pkg::OP_ACC_PAL: begin
                    n_acc = r_acc + palette;
                end
                default: begin
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_var       <= dibbmp_pkg::VAR_NONE;
            r_last      <= 1'b0;
            r_pc        <= dibbmp_pkg::PC_IDLE;
            r_rep       <= '0;
            r_raddr     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_var       <= n_var;
            r_last      <= n_last;
            r_pc        <= n_pc;
            r_rep       <= n_rep;
            r_raddr     <= n_raddr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and captured header fields.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_acc <= n_acc;
        if (accept) begin
            r_total <= n_total;
        end
        if (wr_en) begin
            case (r_pos[dibbmp_pkg::HDR_AW-1:0]) inside
                [6'd0:6'd3]:   r_hsize[{r_pos[1:0], 3'b000} +: 8] <= i_in_data.in_byte;
                [6'd14:6'd15]: r_bits[{r_pos[0], 3'b000} +: 8]    <= i_in_data.in_byte;
                [6'd16:6'd19]: r_comp[{r_pos[1:0], 3'b000} +: 8]  <= i_in_data.in_byte;
                [6'd32:6'd35]: r_used[{r_pos[1:0], 3'b000} +: 8]  <= i_in_data.in_byte;
                default: begin
                end
            endcase
        end
    end

    // Header store: one write port, registered read at the next address.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_pos[dibbmp_pkg::HDR_AW-1:0]] <= i_in_data.in_byte;
        end
        r_rdata <= mem[n_raddr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A decided variant only exists past the decision byte.
    a_var_after_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_var != dibbmp_pkg::VAR_NONE) |-> (r_pos > dibbmp_pkg::DECIDE_POS))
        else $error("variant set before the decision byte");

    // The repeat counter never runs past the step's count.
    a_rep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep <= w.cnt)
        else $error("microcode repeat counter overrun");

    // An error result is the single, final result of its image.
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status) |->
        (o_out_data.output_length == 32'd0 && o_out_data.image_end && o_out_data.run_end))
        else $error("malformed error result");

    // A finished burst returns the sequencer to waiting for input.
    a_burst_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_done && w.fin) |=> (r_pc == dibbmp_pkg::PC_IDLE))
        else $error("sequencer did not return after a run");

endmodule

FILE: tb/sv/dib_to_bmp_header_wrapper_unit_tb.sv
// Self-checking testbench of the DIB to BMP file wrapper: random bitmaps in, BMP bytes checked.
module dib_to_bmp_header_wrapper_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
    localparam int DRAIN_CYCLES   = 60;    // margin for the longest burst
    localparam int SOURCE_ITEMS   = 480;

    // Kinds of bitmap header the generator builds.
    typedef enum logic [2:0] {
        HDR_PASS,      // file already starts with "BM"
        HDR_RGBA32,    // 40-byte header, 32 bpp, uncompressed: gets rewritten
        HDR_PALETTE,   // 1..8 bpp with a color table
        HDR_FIELDS,    // 40-byte header, compression 1, 2 or 3 (bitfields)
        HDR_NOISE      // random bytes throughout
    } t_hdr_kind;

    // How the length field behaves across the bytes of one bitmap.
    typedef enum logic [2:0] {
        LEN_EXACT,     // true byte count on every byte
        LEN_SHORT,     // fewer than 40 bytes
        LEN_CUT,       // decided at byte 35 unless it is the final byte, ends before byte 40
        LEN_WIDE,      // random wide length per byte, any small value on the final one
        LEN_TOP        // length close to 2^32 so the file size wraps unless passed
    } t_len_kind;

    // One pending source byte; hold makes the sender wait for an empty scoreboard first.
    typedef struct packed {
        logic            hold;
        dibbmp_pkg::t_in item;
    } t_feed;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             in_valid  = 1'b0;
    dibbmp_pkg::t_in  in_data   = '0;
    logic             out_ready = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    dibbmp_pkg::t_out o_out_data;

    t_feed            source_feed[$];     // source bytes not yet offered
    dibbmp_pkg::t_out file_bytes_due[$];  // BMP bytes predicted but not yet seen

    // Shadow of the wrapper state.
    logic [31:0]      img_pos;
    logic [7:0]       hdr_bytes [0:39];
    dibbmp_pkg::t_var img_var;

    int n_sent    = 0;
    int n_queued  = 0;
    int n_checked = 0;
    int n_err     = 0;
    int n_images  = 0;
    int n_pass    = 0;
    int n_plain   = 0;
    int n_rewrite = 0;
    int n_short   = 0;
    int stall_cycles = 0;

    // Neither side idles while this window of source bytes goes through.
    wire quiet = (n_sent >= 240) && (n_sent < 330);

    dib_to_bmp_header_wrapper_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // File byte predictor
    // ------------------------------------------------------------------

    function automatic void put_byte(logic [7:0] b, logic [31:0] total);
        dibbmp_pkg::t_out r;
        r = '0;
        r.out_byte      = b;
        r.output_length = total;
        file_bytes_due.push_back(r);
    endfunction

    function automatic void put_le32(logic [31:0] v, logic [31:0] total);
        for (int k = 0; k < 4; k++) put_byte(v[8*k +: 8], total);
    endfunction

    // "BM", file size, two reserved words, pixel offset.
    function automatic void put_file_header(logic [31:0] total, logic [31:0] offs);
        put_byte(dibbmp_pkg::CHAR_B, total);
        put_byte(dibbmp_pkg::CHAR_M, total);
        put_le32(total, total);
        put_le32(32'd0, total);
        put_le32(offs, total);
    endfunction

    function automatic logic [31:0] hdr_word(int at);
        return {hdr_bytes[at+3], hdr_bytes[at+2], hdr_bytes[at+1], hdr_bytes[at]};
    endfunction

    function automatic logic [31:0] bmp_total_for(logic [31:0] len);
        case (img_var)
            dibbmp_pkg::VAR_PASS:    return len;
            dibbmp_pkg::VAR_REWRITE: return len + dibbmp_pkg::REWRITE_GROW;
            default:                 return len + dibbmp_pkg::FILE_HDR_LEN;
        endcase
    endfunction

    // Work out every BMP byte that one accepted source byte releases.
    function automatic void wrap_source_byte(dibbmp_pkg::t_in it);
        logic [31:0]      len, p, total, hsize, comp, used, offs, pal;
        logic [15:0]      bpp;
        logic             final_byte;
        int               n0;
        dibbmp_pkg::t_out r;
        len = it.image_length;
        p   = img_pos;
        final_byte = ({1'b0, p} + 33'd1) >= {1'b0, len};
        n0 = file_bytes_due.size();
        if (p < 40) hdr_bytes[p] = it.in_byte;

        if (img_var == dibbmp_pkg::VAR_NONE) begin
            // Byte 35 decides the variant and releases the header burst.
            if (p == dibbmp_pkg::DECIDE_POS && len >= dibbmp_pkg::MIN_LEN) begin
                hsize = hdr_word(0);
                comp  = hdr_word(16);
                used  = hdr_word(32);
                bpp   = {hdr_bytes[15], hdr_bytes[14]};
                if (hdr_bytes[0] == dibbmp_pkg::CHAR_B && hdr_bytes[1] == dibbmp_pkg::CHAR_M)
                begin
                    img_var = dibbmp_pkg::VAR_PASS;
                    n_pass++;
                    total = bmp_total_for(len);
                    for (int k = 0; k <= 35; k++) put_byte(hdr_bytes[k], total);
                end else if (bpp == dibbmp_pkg::BPP_32 && hsize == dibbmp_pkg::INFO_HDR40 &&
                             comp == dibbmp_pkg::COMP_RGB) begin
                    img_var = dibbmp_pkg::VAR_REWRITE;
                    n_rewrite++;
                    total = bmp_total_for(len);
                    put_file_header(total, 32'(dibbmp_pkg::REWRITE_OFFS));
                    put_le32(32'(dibbmp_pkg::INFO_HDR56), total);
                    for (int k = 4; k <= 15; k++) put_byte(hdr_bytes[k], total);
                    put_le32(dibbmp_pkg::COMP_FIELDS, total);
                    for (int k = 20; k <= 35; k++) put_byte(hdr_bytes[k], total);
                end else begin
                    img_var = dibbmp_pkg::VAR_PLAIN;
                    n_plain++;
                    total = bmp_total_for(len);
                    pal = 32'd0;
                    if (bpp >= 16'd1 && bpp <= dibbmp_pkg::BPP_8)
                        pal = ((used != 32'd0) ? used : (32'd1 << bpp)) * 32'd4;
                    offs = dibbmp_pkg::FILE_HDR_LEN + hsize + pal +
                           ((comp == dibbmp_pkg::COMP_FIELDS && hsize == dibbmp_pkg::INFO_HDR40)
                            ? dibbmp_pkg::FIELDS_LEN : 32'd0);
                    put_file_header(total, offs);
                    for (int k = 0; k <= 35; k++) put_byte(hdr_bytes[k], total);
                end
            end
        end else begin
            total = bmp_total_for(len);
            put_byte(it.in_byte, total);
            // Rewrite: after source byte 39 append the R, G, B and A masks.
            if (img_var == dibbmp_pkg::VAR_REWRITE && p == dibbmp_pkg::MASK_POS)
                for (int k = 0; k < 16; k++)
                    put_byte((k % 5 == 0) ? dibbmp_pkg::MASK_BYTE : 8'h00, total);
        end

        if (final_byte) begin
            if (img_var == dibbmp_pkg::VAR_NONE) begin
                r = '0;
                r.status = 1'b1;
                file_bytes_due.push_back(r);
                n_short++;
            end
            n_images++;
            img_pos = 32'd0;
            img_var = dibbmp_pkg::VAR_NONE;
        end else begin
            img_pos = p + 32'd1;
        end

        // Flag the close of this run, and of the image on its final byte.
        if (file_bytes_due.size() > n0) begin
            r = file_bytes_due.pop_back();
            r.run_end   = 1'b1;
            r.image_end = final_byte;
            file_bytes_due.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    function automatic void queue_byte(logic [7:0] b, logic [31:0] len, logic hold);
        t_feed f;
        f.hold = hold;
        f.item.in_byte      = b;
        f.item.image_length = len;
        source_feed.push_back(f);
        n_queued++;
    endfunction

    // Build one bitmap of the given header kind and length behavior.
    function automatic void queue_image(t_hdr_kind hk, t_len_kind lk, logic hold);
        logic [7:0]  img [0:63];
        logic [31:0] len;
        int          nb;
        case (lk)
            LEN_EXACT: nb = 40 + $urandom_range(24);
            LEN_SHORT: nb = $urandom_range(1) ? $urandom_range(36, 39) : $urandom_range(1, 35);
            LEN_CUT:   nb = $urandom_range(36, 39);
            default:   nb = $urandom_range(36, 56);
        endcase
        for (int i = 0; i < 64; i++) img[i] = 8'($urandom);

        case (hk)
            HDR_PASS: begin
                img[0] = dibbmp_pkg::CHAR_B;
                img[1] = dibbmp_pkg::CHAR_M;
            end
            HDR_RGBA32: begin
                {img[3], img[2], img[1], img[0]}     = dibbmp_pkg::INFO_HDR40;
                {img[15], img[14]}                   = dibbmp_pkg::BPP_32;
                {img[19], img[18], img[17], img[16]} = dibbmp_pkg::COMP_RGB;
            end
            HDR_PALETTE: begin
                case ($urandom_range(3))
                    0:       {img[3], img[2], img[1], img[0]} = 32'd12;
                    1:       {img[3], img[2], img[1], img[0]} = dibbmp_pkg::INFO_HDR40;
                    2:       {img[3], img[2], img[1], img[0]} = 32'd108;
                    default: {img[3], img[2], img[1], img[0]} = 32'd124;
                endcase
                {img[15], img[14]}                   = 16'($urandom_range(1, 8));
                {img[19], img[18], img[17], img[16]} = 32'($urandom_range(3));
                case ($urandom_range(2))
                    0:       {img[35], img[34], img[33], img[32]} = 32'd0;
                    1:       {img[35], img[34], img[33], img[32]} = 32'($urandom_range(1, 256));
                    default: {img[35], img[34], img[33], img[32]} = $urandom;
                endcase
            end
            HDR_FIELDS: begin
                {img[3], img[2], img[1], img[0]} = dibbmp_pkg::INFO_HDR40;
                {img[15], img[14]} = $urandom_range(1) ? dibbmp_pkg::BPP_32 : 16'd16;
                // 32 bpp with compression 1 or 2 is near a rewrite but stays plain
                {img[19], img[18], img[17], img[16]} =
                    $urandom_range(1) ? dibbmp_pkg::COMP_FIELDS : 32'($urandom_range(1, 2));
            end
            default: ;
        endcase

        for (int i = 0; i < nb; i++) begin
            case (lk)
                LEN_CUT:  len = (i == nb - 1) ? 32'(nb)
                                              : dibbmp_pkg::MIN_LEN + $urandom_range(200);
                LEN_WIDE: len = (i == nb - 1) ? 32'($urandom_range(nb, 0)) : ($urandom | 32'h100);
                LEN_TOP:  len = (i == nb - 1) ? 32'(nb) : 32'hFFFF_FFFF - $urandom_range(31);
                default:  len = 32'(nb);
            endcase
            queue_byte(img[i], len, hold && (i == 0));
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer source bytes, predict on every accepted transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_feed nxt;
        logic  gap;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                wrap_source_byte(in_data);
                n_sent <= n_sent + 1;
            end
            gap = !quiet && ($urandom_range(99) < 31);
            // Load the next byte only once the current one has transferred;
            // a held byte waits until every predicted file byte has arrived.
            if (!in_valid || o_in_ready) begin
                if (source_feed.size() != 0 && !gap &&
                    !(source_feed[0].hold && file_bytes_due.size() != 0)) begin
                    nxt = source_feed.pop_front();
                    in_valid <= 1'b1;
                    in_data  <= nxt.item;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(string fld, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
            n_err++;
        end
    endfunction

    always @(posedge i_clk) begin
        dibbmp_pkg::t_out want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                n_checked++;
                if (file_bytes_due.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, o_out_data);
                    n_err++;
                end else begin
                    want = file_bytes_due.pop_front();
                    check_field("out_byte", 32'(want.out_byte), 32'(o_out_data.out_byte));
                    check_field("output_length", want.output_length,
                                o_out_data.output_length);
                    check_field("status", 32'(want.status), 32'(o_out_data.status));
                    check_field("run_end", 32'(want.run_end), 32'(o_out_data.run_end));
                    check_field("image_end", 32'(want.image_end), 32'(o_out_data.image_end));
                end
            end
            // Stall the result side at random, except inside the quiet window.
            out_ready <= quiet || ($urandom_range(99) >= 31);
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, stall_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: fill the feed, release reset, drain, report
    // ------------------------------------------------------------------
    initial begin
        int r;
        t_len_kind lk;
        img_pos = 32'd0;
        img_var = dibbmp_pkg::VAR_NONE;
        for (int i = 0; i < 40; i++) hdr_bytes[i] = 8'h00;

        // Short bitmaps: zero length, one byte, an all-ones length cut to two
        // bytes, and a three-byte file that starts with "BM".
        queue_byte(8'h00, 32'd0, 1'b0);
        queue_byte(8'hFF, 32'd1, 1'b0);
        queue_byte(8'h5A, 32'hFFFF_FFFF, 1'b0);
        queue_byte(8'hA5, 32'd2, 1'b0);
        queue_byte(dibbmp_pkg::CHAR_B, 32'd3, 1'b0);
        queue_byte(dibbmp_pkg::CHAR_M, 32'd3, 1'b0);
        queue_byte(8'h80, 32'd3, 1'b0);

        // One of each variant, then the length corner cases.
        queue_image(HDR_PASS, LEN_EXACT, 1'b1);
        queue_image(HDR_RGBA32, LEN_EXACT, 1'b0);
        queue_image(HDR_PALETTE, LEN_EXACT, 1'b0);
        queue_image(HDR_FIELDS, LEN_EXACT, 1'b0);
        queue_image(HDR_RGBA32, LEN_CUT, 1'b1);
        // Palette header with a wrapping length: pixel offset arithmetic and
        // the wrapped file size meet in one bitmap.
        queue_image(HDR_PALETTE, LEN_TOP, 1'b0);
        queue_image(HDR_NOISE, LEN_SHORT, 1'b0);
        queue_image(HDR_RGBA32, LEN_WIDE, 1'b0);

        // Random part: mostly well-formed bitmaps with random content.
        for (int n = 0; n_queued < SOURCE_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < 60)      lk = LEN_EXACT;
            else if (r < 72) lk = LEN_SHORT;
            else if (r < 82) lk = LEN_CUT;
            else if (r < 92) lk = LEN_WIDE;
            else             lk = LEN_TOP;
            queue_image(t_hdr_kind'($urandom_range(4)), lk, (n % 6) == 0);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every byte to transfer and every prediction to be met.
        while (source_feed.size() != 0 || in_valid || file_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (file_bytes_due.size() != 0) begin
            $display("%0t: %0d predicted file bytes never arrived, next expected %h",
                     $time, file_bytes_due.size(), file_bytes_due[0]);
            n_err++;
        end

        $display("Sent %0d source bytes in %0d bitmaps: %0d pass, %0d plain, %0d rewrite,",
                 n_sent, n_images, n_pass, n_plain, n_rewrite);
        $display("%0d short; checked %0d BMP output bytes, %0d mismatches.",
                 n_short, n_checked, n_err);
        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
